// ===== hw/rtl/rwg_pkg.sv =====
// ----------------------------------------------------------------------------
// rwg_pkg
// Shared constants, codes and command/status types of the wave grid step core.
// ----------------------------------------------------------------------------
package rwg_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int CELLS    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W   = $clog2(MAX_COLS + 1);

   localparam int FUNC_W    = 2;
   localparam int ROWF_W    = 6;
   localparam int COLF_W    = 6;
   localparam int HEIGHT_W  = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;
   localparam int CNT_CFG_W = 7;
   localparam int RELAX_W   = 15;

   localparam logic [CNT_CFG_W-1:0] ROWS_RESET  = 7'd64;
   localparam logic [CNT_CFG_W-1:0] COLS_RESET  = 7'd64;
   localparam logic [RELAX_W-1:0]   RELAX_RESET = 15'd32081;
   localparam logic [HEIGHT_W-1:0]  REST_RESET  = 32'd0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_STEP  = 2'd2,
      FUNC_FILL  = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS  = 2'd0,
      CSR_COLS  = 2'd1,
      CSR_RELAX = 2'd2,
      CSR_REST  = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      WSEL_HEIGHT,
      WSEL_REST,
      WSEL_ZERO,
      WSEL_NEXT,
      WSEL_CUR
   } wsel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_NS,
      ST_EW,
      ST_SUM,
      ST_MUL,
      ST_NEXT,
      ST_FROZEN,
      ST_FILL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              take_req;
      logic [ADDR_W-1:0] rd0_addr;
      logic [ADDR_W-1:0] rd1_addr;
      logic [ADDR_W-1:0] wr_addr;
      logic              wr_cur;
      logic              wr_prv;
      wsel_type          wsel;
      logic              cap_ns;
      logic              cap_sum;
      logic              cap_mul;
      logic              flip;
      logic              load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      func_type          func;
      logic              in_grid;
      logic [ADDR_W-1:0] req_addr;
      logic [RCNT_W-1:0] n_rows;
      logic [CCNT_W-1:0] n_cols;
   } dp_stat_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      cell_addr = ADDR_W'(int'(r) * MAX_COLS + int'(c));
   endfunction

endpackage

// ===== hw/rtl/rwg_if.sv =====
// ----------------------------------------------------------------------------
// rwg_if
// Request and response channels of the wave grid step core.
// ----------------------------------------------------------------------------
interface rwg_req_if
   import rwg_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [ROWF_W-1:0]   row;
   logic [COLF_W-1:0]   col;
   logic [HEIGHT_W-1:0] height;

   modport source (output valid, func, row, col, height, input ready);
   modport sink   (input valid, func, row, col, height, output ready);
endinterface

interface rwg_rsp_if
   import rwg_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [HEIGHT_W-1:0] read_height;
   logic [FUNC_W-1:0]   done_func;

   modport source (output valid, read_height, done_func, input ready);
   modport sink   (input valid, read_height, done_func, output ready);
endinterface

// ===== hw/rtl/rwg_ram.sv =====
// ----------------------------------------------------------------------------
// rwg_ram
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rwg_ram #(
   parameter int AW = 12,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr0,
   input  logic [AW-1:0] raddr1,
   output logic [DW-1:0] q0,
   output logic [DW-1:0] q1
);
   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] q0_ff;
   logic [DW-1:0] q1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      q0_ff <= mem[raddr0];
      q1_ff <= mem[raddr1];
   end

   assign q0 = q0_ff;
   assign q1 = q1_ff;
endmodule

// ===== hw/rtl/rwg_datapath.sv =====
// ----------------------------------------------------------------------------
// rwg_datapath
// Config registers, both height grids, stencil arithmetic and response register.
// ----------------------------------------------------------------------------
module rwg_datapath
   import rwg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [FUNC_W-1:0]    req_func,
   input  logic [ROWF_W-1:0]    req_row,
   input  logic [COLF_W-1:0]    req_col,
   input  logic [HEIGHT_W-1:0]  req_height,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   output logic [HEIGHT_W-1:0]  rsp_read_height,
   output logic [FUNC_W-1:0]    rsp_done_func
);
   logic [CNT_CFG_W-1:0] rows_ff, cols_ff;
   logic [RELAX_W-1:0]   relax_ff;
   logic [HEIGHT_W-1:0]  rest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= ROWS_RESET;
         cols_ff  <= COLS_RESET;
         relax_ff <= RELAX_RESET;
         rest_ff  <= REST_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ROWS:  rows_ff  <= csr_wdata[CNT_CFG_W-1:0];
            CSR_COLS:  cols_ff  <= csr_wdata[CNT_CFG_W-1:0];
            CSR_RELAX: relax_ff <= csr_wdata[RELAX_W-1:0];
            CSR_REST:  rest_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // region size, zero acts as one, oversize acts as the grid size
   always_comb begin
      if (rows_ff == '0) stat.n_rows = RCNT_W'(1);
      else if (int'(rows_ff) > MAX_ROWS) stat.n_rows = RCNT_W'(MAX_ROWS);
      else stat.n_rows = RCNT_W'(rows_ff);
      if (cols_ff == '0) stat.n_cols = CCNT_W'(1);
      else if (int'(cols_ff) > MAX_COLS) stat.n_cols = CCNT_W'(MAX_COLS);
      else stat.n_cols = CCNT_W'(cols_ff);
   end

   // latched request
   func_type            func_ff;
   logic                in_grid_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [HEIGHT_W-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         func_ff    <= func_type'(req_func);
         in_grid_ff <= (int'(req_row) < MAX_ROWS) && (int'(req_col) < MAX_COLS);
         addr_ff    <= cell_addr(ROW_W'(req_row), COL_W'(req_col));
         height_ff  <= req_height;
      end
   end

   assign stat.func     = func_ff;
   assign stat.in_grid  = in_grid_ff;
   assign stat.req_addr = addr_ff;

   // grid selection
   logic cur_is_b_ff;
   always_ff @(posedge clock) begin
      if (reset) cur_is_b_ff <= 1'b0;
      else if (cmd.flip) cur_is_b_ff <= ~cur_is_b_ff;
   end

   logic [HEIGHT_W-1:0] a_q0, a_q1, b_q0, b_q1, wdata;
   logic [HEIGHT_W-1:0] cur_d0, cur_d1, prv_d;
   logic                a_we, b_we;
   logic [ADDR_W-1:0]   a_ra0, b_ra0;
   logic [HEIGHT_W-1:0] next_val;

   assign a_ra0  = cur_is_b_ff ? cmd.wr_addr : cmd.rd0_addr;
   assign b_ra0  = cur_is_b_ff ? cmd.rd0_addr : cmd.wr_addr;
   assign cur_d0 = cur_is_b_ff ? b_q0 : a_q0;
   assign cur_d1 = cur_is_b_ff ? b_q1 : a_q1;
   assign prv_d  = cur_is_b_ff ? a_q0 : b_q0;
   assign a_we   = cur_is_b_ff ? cmd.wr_prv : cmd.wr_cur;
   assign b_we   = cur_is_b_ff ? cmd.wr_cur : cmd.wr_prv;

   always_comb begin
      unique case (cmd.wsel)
         WSEL_HEIGHT: wdata = height_ff;
         WSEL_REST:   wdata = rest_ff;
         WSEL_ZERO:   wdata = '0;
         WSEL_NEXT:   wdata = next_val;
         WSEL_CUR:    wdata = cur_d0;
         default:     wdata = '0;
      endcase
   end

   rwg_ram #(.AW(ADDR_W), .DW(HEIGHT_W)) u_grid_a (
      .clock (clock), .we (a_we), .waddr (cmd.wr_addr), .wdata (wdata),
      .raddr0 (a_ra0), .raddr1 (cmd.rd1_addr), .q0 (a_q0), .q1 (a_q1)
   );

   rwg_ram #(.AW(ADDR_W), .DW(HEIGHT_W)) u_grid_b (
      .clock (clock), .we (b_we), .waddr (cmd.wr_addr), .wdata (wdata),
      .raddr0 (b_ra0), .raddr1 (cmd.rd1_addr), .q0 (b_q0), .q1 (b_q1)
   );

   // stencil pipeline
   logic signed [32:0] sum_ns_ff, sum_ns_in;
   logic signed [33:0] sum_ff, sum_in;
   logic signed [31:0] p_ff;
   logic signed [16:0] k_w;
   logic signed [48:0] prod_p_ff, prod_p_in;
   logic signed [49:0] prod_s_ff, prod_s_in;
   logic signed [53:0] acc;

   assign sum_ns_in = $signed({cur_d0[31], cur_d0}) + $signed({cur_d1[31], cur_d1});
   assign sum_in    = $signed({sum_ns_ff[32], sum_ns_ff})
                    + $signed({{2{cur_d0[31]}}, cur_d0})
                    + $signed({{2{cur_d1[31]}}, cur_d1});
   assign k_w       = 17'sd16384 - $signed({2'b00, relax_ff});
   assign prod_p_in = k_w * p_ff;
   assign prod_s_in = $signed({1'b0, relax_ff}) * sum_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap_ns) sum_ns_ff <= sum_ns_in;
      if (cmd.cap_sum) begin
         sum_ff <= sum_in;
         p_ff   <= $signed(prv_d);
      end
      if (cmd.cap_mul) begin
         prod_p_ff <= prod_p_in;
         prod_s_ff <= prod_s_in;
      end
   end

   assign acc = $signed({{3{prod_p_ff[48]}}, prod_p_ff, 2'b00})
              + $signed({{4{prod_s_ff[49]}}, prod_s_ff});

   // floor by dropping low bits, then saturate
   always_comb begin
      if ((acc[53:47] == '0) || (acc[53:47] == '1)) next_val = acc[47:16];
      else if (acc[53]) next_val = 32'h8000_0000;
      else next_val = 32'h7FFF_FFFF;
   end

   // response register
   logic [HEIGHT_W-1:0] rsp_height_ff;
   logic [FUNC_W-1:0]   rsp_func_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_height_ff <= ((func_ff == FUNC_READ) && in_grid_ff) ? cur_d0 : '0;
         rsp_func_ff   <= func_ff;
      end
   end

   assign rsp_read_height = rsp_height_ff;
   assign rsp_done_func   = rsp_func_ff;
endmodule

// ===== hw/rtl/rwg_ctrl.sv =====
// ----------------------------------------------------------------------------
// rwg_ctrl
// Operation sequencer: clearing pass, cell sweeps and response handshake.
// ----------------------------------------------------------------------------
module rwg_ctrl
   import rwg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);
   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  r_ff, r_in;
   logic [COL_W-1:0]  c_ff, c_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         r_ff         <= '0;
         c_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   logic              last_c, last_r, in_region;
   logic [ROW_W-1:0]  r_up, r_dn;
   logic [COL_W-1:0]  c_lf, c_rt;
   logic [ADDR_W-1:0] idx;

   assign last_c    = (c_ff == COL_W'(MAX_COLS - 1));
   assign last_r    = (r_ff == ROW_W'(MAX_ROWS - 1));
   assign in_region = (int'(r_ff) < int'(stat.n_rows)) && (int'(c_ff) < int'(stat.n_cols));
   assign idx       = cell_addr(r_ff, c_ff);

   // neighbors clamp to the edge of the region
   always_comb begin
      r_up = (r_ff == '0) ? r_ff : r_ff - 1'b1;
      c_lf = (c_ff == '0) ? c_ff : c_ff - 1'b1;
      if (int'(r_ff) + 1 >= int'(stat.n_rows)) r_dn = ROW_W'(int'(stat.n_rows) - 1);
      else r_dn = r_ff + 1'b1;
      if (int'(c_ff) + 1 >= int'(stat.n_cols)) c_rt = COL_W'(int'(stat.n_cols) - 1);
      else c_rt = c_ff + 1'b1;
   end

   always_comb begin
      logic advance;
      logic done;
      advance      = 1'b0;
      done         = last_r && last_c;
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.rd0_addr = stat.req_addr;
      cmd.rd1_addr = stat.req_addr;
      cmd.wr_addr  = idx;
      cmd.wsel     = WSEL_ZERO;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.wr_cur = 1'b1;
            cmd.wr_prv = 1'b1;
            advance    = 1'b1;
            if (done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.take_req = req_valid;
            if (req_valid) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // decode the latched operation here
            unique case (stat.func)
               FUNC_WRITE: begin
                  cmd.wr_addr = stat.req_addr;
                  cmd.wr_cur  = stat.in_grid;
                  cmd.wsel    = WSEL_HEIGHT;
                  state_in    = ST_RESP;
               end
               FUNC_READ: state_in = ST_READ;
               FUNC_STEP: state_in = ST_NS;
               FUNC_FILL: state_in = ST_FILL;
               default:   state_in = ST_RESP;
            endcase
         end
         ST_READ: state_in = ST_RESP;
         ST_NS: begin
            if (in_region) begin
               cmd.rd0_addr = cell_addr(r_up, c_ff);
               cmd.rd1_addr = cell_addr(r_dn, c_ff);
               state_in     = ST_EW;
            end else begin
               cmd.rd0_addr = idx;
               state_in     = ST_FROZEN;
            end
         end
         ST_FROZEN: begin
            cmd.wr_prv = 1'b1;
            cmd.wsel   = WSEL_CUR;
            advance    = 1'b1;
            state_in   = done ? ST_RESP : ST_NS;
         end
         ST_EW: begin
            cmd.rd0_addr = cell_addr(r_ff, c_lf);
            cmd.rd1_addr = cell_addr(r_ff, c_rt);
            cmd.cap_ns   = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.cap_sum = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.cap_mul = 1'b1;
            state_in    = ST_NEXT;
         end
         ST_NEXT: begin
            cmd.wr_prv = 1'b1;
            cmd.wsel   = WSEL_NEXT;
            advance    = 1'b1;
            state_in   = done ? ST_RESP : ST_NS;
         end
         ST_FILL: begin
            cmd.wr_cur = 1'b1;
            cmd.wr_prv = 1'b1;
            cmd.wsel   = WSEL_REST;
            advance    = 1'b1;
            if (done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (advance) begin
         c_in = last_c ? '0 : c_ff + 1'b1;
         if (last_c) r_in = last_r ? '0 : r_ff + 1'b1;
         cmd.flip = done && ((state_ff == ST_NEXT) || (state_ff == ST_FROZEN));
      end
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   a_flip_at_sweep_end: assert property (@(posedge clock) disable iff (reset)
      cmd.flip |-> (last_r && last_c))
      else $error("grid swap away from sweep end");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   a_sweep_counters_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (r_ff == '0 && c_ff == '0))
      else $error("sweep counters not rewound");
endmodule

// ===== hw/rtl/relaxed_wave_grid_step_core.sv =====
// ----------------------------------------------------------------------------
// relaxed_wave_grid_step_core
// Two-grid Q16.16 height field with a relaxed five-point stencil step.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation per beat: write cell, read cell, step
//   or fill. rsp returns exactly one beat per request, with the read height
//   (zero unless a read) and the echoed operation code.
//   csr_we/csr_index/csr_wdata write region rows, region columns, relax
//   factor and rest level; write them only while the core is idle.
// Sweeps: fill writes the rest level to every cell of both grids; step
//   takes each region cell through the NS, EW, SUM, MUL and NEXT states and
//   copies each cell outside the region through the NS and FROZEN states.
//   One operation is in flight at a time; the step sweep runs through one
//   cell at a time over the shared grid read ports and one multiply stage.
// Reset: the core clears both grids in a pass over every cell, req_ready is low
//   for that time; config takes its reset values at once.
// Stall: a finished response sits in the output register; the next request
//   is accepted meanwhile, and its response waits until rsp is taken.
// ----------------------------------------------------------------------------
module relaxed_wave_grid_step_core
   import rwg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   rwg_req_if.sink              req_if,
   rwg_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);
   dp_cmd_type  cmd;
   dp_stat_type stat;

   rwg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rwg_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_func        (req_if.func),
      .req_row         (req_if.row),
      .req_col         (req_if.col),
      .req_height      (req_if.height),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_read_height (rsp_if.read_height),
      .rsp_done_func   (rsp_if.done_func)
   );
endmodule
